// ===== rtl/tt_pkg.sv =====
package tt_pkg;

	localparam int SLOTS = 16;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [15:0] MAX_SLEEP_RESET = 16'd1000;
	localparam logic [7:0] RUN_MAX = 8'd255;

	localparam logic [2:0] CMD_TICK = 3'd0;
	localparam logic [2:0] CMD_ADD_ONE = 3'd1;
	localparam logic [2:0] CMD_ADD_PER = 3'd2;
	localparam logic [2:0] CMD_REMOVE = 3'd3;
	localparam logic [2:0] CMD_DONE = 3'd4;

	localparam logic [2:0] KIND_FIRE = 3'd0;
	localparam logic [2:0] KIND_ADDED = 3'd1;
	localparam logic [2:0] KIND_FULL = 3'd2;
	localparam logic [2:0] KIND_ACK = 3'd3;
	localparam logic [2:0] KIND_WAKE = 3'd4;

	localparam logic [1:0] POL_OVERLAP = 2'd0;
	localparam logic [1:0] POL_SKIP = 2'd1;
	localparam logic [1:0] POL_WAIT = 2'd2;

	typedef struct packed {
		logic [2:0] cmd;
		logic [31:0] now_ms;
		logic [31:0] period_ms;
		logic use_worker;
		logic urgent_flag;
		logic [1:0] policy_sel;
		logic [31:0] target_id;
	} in_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [31:0] task_id;
		logic urgent_out;
		logic threaded_out;
		logic [31:0] wake_ms;
		logic found;
		logic last;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;        // capture input item
		logic scan_clr;    // zero the scan index, seed wake time
		logic scan_step;   // process current slot, advance index
		logic do_add;      // commit add / report full
		logic do_lookup;   // one remove/done slot compare step
		logic lookup_fin;  // build remove/done/unknown or tick wake result
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_end;    // index reached slots_used
		logic scan_fire;   // current slot fires
		logic look_end;    // lookup hit or exhausted
		logic is_tick;
		logic is_add;
		logic is_look;
	} dp_stat_t;

endpackage

// ===== rtl/tt_datapath.sv =====
module tt_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data,
	input  tt_pkg::in_item_t    item,
	input  tt_pkg::dp_cmd_t     cmd,
	output tt_pkg::dp_stat_t    stat,
	output tt_pkg::out_item_t   res
);

	logic [15:0] max_sleep_q;
	tt_pkg::in_item_t it_q;
	logic [tt_pkg::SLOTS-1:0] active_q, periodic_q, threaded_q, urgent_q;
	logic [1:0]  policy_q   [tt_pkg::SLOTS];
	logic [7:0]  running_q  [tt_pkg::SLOTS];
	logic [31:0] deadline_q [tt_pkg::SLOTS];
	logic [31:0] interval_q [tt_pkg::SLOTS];
	logic [31:0] ident_q    [tt_pkg::SLOTS];
	logic [tt_pkg::CNT_W-1:0] used_q, idx_q;
	logic [31:0] next_id_q, wake_q;

	logic [tt_pkg::SLOT_W-1:0] ix;
	logic [31:0] dl, dl_diff, new_dl, wk_diff;
	logic due, busy, fire, skip, now_act, waiting;
	logic [7:0] new_run;
	logic [tt_pkg::CNT_W-1:0] free_idx;
	logic free_hit;
	logic look_hit;

	assign ix = idx_q[tt_pkg::SLOT_W-1:0];
	assign dl = deadline_q[ix];
	assign dl_diff = dl - it_q.now_ms;
	assign due = (dl_diff == 32'd0) || dl_diff[31];
	assign busy = running_q[ix] != 8'd0;
	assign fire = active_q[ix] && due &&
		!(busy && (policy_q[ix] == tt_pkg::POL_SKIP || policy_q[ix] == tt_pkg::POL_WAIT));
	assign skip = active_q[ix] && due && busy && policy_q[ix] == tt_pkg::POL_SKIP;
	assign new_dl = (skip || (fire && periodic_q[ix])) ? dl + interval_q[ix] : dl;
	assign new_run = (fire && threaded_q[ix] && running_q[ix] < tt_pkg::RUN_MAX) ?
		running_q[ix] + 8'd1 : running_q[ix];
	assign now_act = active_q[ix] && !(fire && !periodic_q[ix]);
	assign waiting = policy_q[ix] == tt_pkg::POL_WAIT && new_run != 8'd0;
	assign wk_diff = new_dl - wake_q;
	// the lookup stops on a match or past the used slots
	assign look_hit = idx_q < used_q;

	// first reusable slot, priority search over valid entries
	always_comb begin
		free_idx = used_q;
		free_hit = 1'b0;
		for (int i = tt_pkg::SLOTS - 1; i >= 0; i--) begin
			if (i < int'(used_q) && !active_q[i] && running_q[i] == 8'd0) begin
				free_idx = tt_pkg::CNT_W'(i);
				free_hit = 1'b1;
			end
		end
	end

	assign stat.scan_end = idx_q >= used_q;
	assign stat.scan_fire = fire;
	assign stat.look_end = idx_q >= used_q || ident_q[ix] == it_q.target_id;
	assign stat.is_tick = it_q.cmd == tt_pkg::CMD_TICK;
	assign stat.is_add = it_q.cmd == tt_pkg::CMD_ADD_ONE || it_q.cmd == tt_pkg::CMD_ADD_PER;
	assign stat.is_look = it_q.cmd == tt_pkg::CMD_REMOVE || it_q.cmd == tt_pkg::CMD_DONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_sleep_q <= tt_pkg::MAX_SLEEP_RESET;
			active_q <= '0;
			used_q <= '0;
			next_id_q <= 32'd1;
			idx_q <= '0;
			for (int i = 0; i < tt_pkg::SLOTS; i++) begin
				running_q[i] <= 8'd0;
				ident_q[i] <= 32'd0;
			end
		end else begin
			if (cfg_we) max_sleep_q <= cfg_data;
			if (cmd.load) it_q <= item;
			if (cmd.scan_clr) begin
				idx_q <= '0;
				wake_q <= it_q.now_ms + {16'd0, max_sleep_q};
			end
			if (cmd.scan_step) begin
				deadline_q[ix] <= new_dl;
				running_q[ix] <= new_run;
				active_q[ix] <= now_act;
				if (now_act && !waiting && wk_diff[31]) wake_q <= new_dl;
				idx_q <= idx_q + 1'b1;
				res <= '{kind: fire ? tt_pkg::KIND_FIRE : tt_pkg::KIND_WAKE,
					task_id: ident_q[ix], urgent_out: urgent_q[ix],
					threaded_out: threaded_q[ix], wake_ms: 32'd0, found: 1'b0, last: 1'b0};
			end
			if (cmd.do_lookup) idx_q <= idx_q + 1'b1;
			if (cmd.lookup_fin) begin
				res <= '{kind: stat.is_tick ? tt_pkg::KIND_WAKE : tt_pkg::KIND_ACK,
					task_id: 32'd0, urgent_out: 1'b0, threaded_out: 1'b0,
					wake_ms: stat.is_tick ? wake_q : 32'd0,
					found: stat.is_look && look_hit, last: 1'b1};
				if (stat.is_look && look_hit) begin
					if (it_q.cmd == tt_pkg::CMD_REMOVE) active_q[ix] <= 1'b0;
					else if (running_q[ix] != 8'd0) running_q[ix] <= running_q[ix] - 8'd1;
				end
			end
			if (cmd.do_add) begin
				if (free_hit || used_q < tt_pkg::CNT_W'(tt_pkg::SLOTS)) begin
					if (!free_hit) used_q <= used_q + 1'b1;
					res <= '{kind: tt_pkg::KIND_ADDED, task_id: next_id_q, urgent_out: 1'b0,
						threaded_out: 1'b0, wake_ms: 32'd0, found: 1'b0, last: 1'b1};
					next_id_q <= next_id_q + 32'd1;
					ident_q[free_idx[tt_pkg::SLOT_W-1:0]] <= next_id_q;
					active_q[free_idx[tt_pkg::SLOT_W-1:0]] <= 1'b1;
					urgent_q[free_idx[tt_pkg::SLOT_W-1:0]] <= it_q.urgent_flag;
					running_q[free_idx[tt_pkg::SLOT_W-1:0]] <= 8'd0;
					deadline_q[free_idx[tt_pkg::SLOT_W-1:0]] <= it_q.now_ms + it_q.period_ms;
					if (it_q.cmd == tt_pkg::CMD_ADD_ONE) begin
						periodic_q[free_idx[tt_pkg::SLOT_W-1:0]] <= 1'b0;
						threaded_q[free_idx[tt_pkg::SLOT_W-1:0]] <= 1'b1;
						policy_q[free_idx[tt_pkg::SLOT_W-1:0]] <= tt_pkg::POL_OVERLAP;
						interval_q[free_idx[tt_pkg::SLOT_W-1:0]] <= 32'd0;
					end else begin
						periodic_q[free_idx[tt_pkg::SLOT_W-1:0]] <= 1'b1;
						threaded_q[free_idx[tt_pkg::SLOT_W-1:0]] <= it_q.use_worker;
						policy_q[free_idx[tt_pkg::SLOT_W-1:0]] <=
							(it_q.policy_sel == 2'd3) ? tt_pkg::POL_OVERLAP : it_q.policy_sel;
						interval_q[free_idx[tt_pkg::SLOT_W-1:0]] <= it_q.period_ms;
					end
				end else begin
					res <= '{kind: tt_pkg::KIND_FULL, task_id: 32'd0, urgent_out: 1'b0,
						threaded_out: 1'b0, wake_ms: 32'd0, found: 1'b0, last: 1'b1};
				end
			end
		end
	end

endmodule

// ===== rtl/tt_ctrl.sv =====
module tt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  tt_pkg::dp_stat_t stat,
	output tt_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {IDLE, DECODE, SCAN, LOOK, SEND, EMIT} state_t;
	state_t state_q;

	assign in_ready = state_q == IDLE;
	assign out_valid = state_q == SEND || state_q == EMIT;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && state_q == IDLE;
		case (state_q)
			DECODE: begin
				cmd.scan_clr = 1'b1;
				cmd.do_add = stat.is_add;
				cmd.lookup_fin = !stat.is_add && !stat.is_tick && !stat.is_look;
			end
			SCAN: begin
				cmd.scan_step = !stat.scan_end;
				cmd.lookup_fin = stat.scan_end;
			end
			LOOK: begin
				cmd.do_lookup = !stat.look_end;
				cmd.lookup_fin = stat.look_end;
			end
			default: ;
		endcase
	end

	// SEND carries a fire item and returns to the scan; EMIT carries a final item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			case (state_q)
				IDLE: if (in_valid) state_q <= DECODE;
				DECODE: begin
					if (stat.is_tick) state_q <= SCAN;
					else if (stat.is_look) state_q <= LOOK;
					else state_q <= EMIT;
				end
				SCAN: begin
					if (stat.scan_end) state_q <= EMIT;
					else if (stat.scan_fire) state_q <= SEND;
				end
				LOOK: if (stat.look_end) state_q <= EMIT;
				SEND: if (out_ready) state_q <= SCAN;
				EMIT: if (out_ready) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/timer_table_with_overrun_policy.sv =====
// Timer table with overrun policy.
// Input channel s_axis_*: one command per transfer (tick, add one-shot,
// add periodic, remove, done). Output channel m_axis_*: result transfers;
// a tick yields one fire transfer per fired slot followed by a wake
// transfer; every other command yields one transfer. tlast marks the final
// result of a command.
// Config: cfg_we/cfg_data write max_sleep_ms (reset 1000); the user must
// write it only while idle, as the block itself does not enforce this.
// A remove or done searches the used slots in order until the id matches;
// a tick scans every used slot in order.
// One command is in flight at a time; the slot scan (one slot a cycle
// through the shared datapath, pausing for each fire transfer until it is
// taken) sets the rate of a tick over the 16-slot table.
// Reset: table empty, next id 1, no transfer pending.
// Stall: when m_axis_tready is low the result register holds and the scan
// stops until the transfer completes; s_axis_tready stays low meanwhile.
module timer_table_with_overrun_policy (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// now_ms, period_ms, use_worker, urgent_flag, target_id from low bit up
	input  logic [103:0] s_axis_tdata,
	// cmd [2:0], policy_sel [4:3] from low bit up
	input  logic [4:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// task_id, urgent_out, threaded_out, wake_ms, found from low bit up
	output logic [71:0]  m_axis_tdata,
	// kind
	output logic [2:0]   m_axis_tuser,
	output logic         m_axis_tlast
);

	tt_pkg::in_item_t  item;
	tt_pkg::out_item_t res;
	tt_pkg::dp_cmd_t   cmd;
	tt_pkg::dp_stat_t  stat;

	assign item.cmd = s_axis_tuser[2:0];
	assign item.policy_sel = s_axis_tuser[4:3];
	assign item.now_ms = s_axis_tdata[31:0];
	assign item.period_ms = s_axis_tdata[63:32];
	assign item.use_worker = s_axis_tdata[64];
	assign item.urgent_flag = s_axis_tdata[65];
	assign item.target_id = s_axis_tdata[97:66];

	assign m_axis_tdata = {5'd0, res.found, res.wake_ms, res.threaded_out,
		res.urgent_out, res.task_id};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

	tt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.stat(stat), .cmd(cmd)
	);

	tt_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.item(item), .cmd(cmd), .stat(stat), .res(res)
	);

endmodule

// ===== rtl/tt_checker.sv =====
module tt_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [2:0]   m_axis_tuser,
	input logic         m_axis_tlast
);

	ap_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input taken during output");
	ap_fire_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == tt_pkg::KIND_FIRE |-> !m_axis_tlast)
		else $error("fire marked last");
	ap_wake_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == tt_pkg::KIND_WAKE |-> m_axis_tlast)
		else $error("wake not last");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
		else $error("output dropped");

endmodule

bind timer_table_with_overrun_policy tt_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);

// ===== bench/tb_timer_table_with_overrun_policy.sv =====
`timescale 1ns / 100ps

module tb_timer_table_with_overrun_policy;

	localparam int WATCHDOG_LIMIT = 4000;

	// Expected result of one output transfer.
	typedef struct packed {
		logic [2:0] kind;
		logic [31:0] task_id;
		logic urgent_out;
		logic threaded_out;
		logic [31:0] wake_ms;
		logic found;
		logic last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [103:0] s_axis_tdata = '0;
	logic [4:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic m_axis_tlast;

	timer_table_with_overrun_policy dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the timer table.
	logic [15:0] sleep_cap;
	logic tbl_active[tt_pkg::SLOTS];
	logic tbl_periodic[tt_pkg::SLOTS];
	logic tbl_threaded[tt_pkg::SLOTS];
	logic tbl_urgent[tt_pkg::SLOTS];
	logic [1:0] tbl_policy[tt_pkg::SLOTS];
	logic [7:0] tbl_running[tt_pkg::SLOTS];
	logic [31:0] tbl_deadline[tt_pkg::SLOTS];
	logic [31:0] tbl_interval[tt_pkg::SLOTS];
	logic [31:0] tbl_ident[tt_pkg::SLOTS];
	int tbl_used;
	logic [31:0] ident_next;

	result_t pending_results[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int out_wait = 0;
	bit timed_out = 0;
	logic [31:0] clock_ms = 32'd0;

	// Signed difference a - b <= 0.
	function automatic bit due_by(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d == 0 || d[31];
	endfunction

	function automatic result_t mk(logic [2:0] k, logic [31:0] id, logic u, logic t,
			logic [31:0] w, logic f, logic l);
		result_t r;
		r.kind = k; r.task_id = id; r.urgent_out = u; r.threaded_out = t;
		r.wake_ms = w; r.found = f; r.last = l;
		return r;
	endfunction

	// Apply one command to the shadow table and queue the results it causes.
	task automatic predict_command(logic [2:0] cmd, logic [31:0] now, logic [31:0] per,
			logic worker, logic urg, logic [1:0] pol, logic [31:0] tid);
		logic [31:0] wake;
		logic [31:0] d;
		bit go;
		int idx;
		wake = now + {16'd0, sleep_cap};
		idx = -1;
		if (cmd == tt_pkg::CMD_TICK) begin
			for (int i = 0; i < tbl_used; i++) begin
				if (!tbl_active[i])
					continue;
				if (due_by(tbl_deadline[i], now)) begin
					go = 1;
					if (tbl_running[i] != 0) begin
						if (tbl_policy[i] == tt_pkg::POL_SKIP) begin
							go = 0;
							tbl_deadline[i] += tbl_interval[i];
						end else if (tbl_policy[i] == tt_pkg::POL_WAIT) begin
							go = 0;
						end
					end
					if (go) begin
						pending_results.push_back(mk(tt_pkg::KIND_FIRE, tbl_ident[i],
							tbl_urgent[i], tbl_threaded[i], 32'd0, 1'b0, 1'b0));
						if (tbl_threaded[i] && tbl_running[i] != tt_pkg::RUN_MAX)
							tbl_running[i]++;
						if (tbl_periodic[i])
							tbl_deadline[i] += tbl_interval[i];
						else
							tbl_active[i] = 0;
					end
				end
				if (tbl_active[i] &&
						!(tbl_policy[i] == tt_pkg::POL_WAIT && tbl_running[i] != 0)) begin
					d = tbl_deadline[i] - wake;
					if (d[31])
						wake = tbl_deadline[i];
				end
			end
			pending_results.push_back(mk(tt_pkg::KIND_WAKE, 32'd0, 1'b0, 1'b0, wake,
				1'b0, 1'b1));
		end else if (cmd == tt_pkg::CMD_ADD_ONE || cmd == tt_pkg::CMD_ADD_PER) begin
			for (int i = 0; i < tbl_used; i++)
				if (!tbl_active[i] && tbl_running[i] == 0) begin
					idx = i;
					break;
				end
			if (idx < 0 && tbl_used < tt_pkg::SLOTS) begin
				idx = tbl_used;
				tbl_used++;
			end
			if (idx < 0) begin
				pending_results.push_back(mk(tt_pkg::KIND_FULL, 32'd0, 1'b0, 1'b0, 32'd0,
					1'b0, 1'b1));
			end else begin
				tbl_ident[idx] = ident_next;
				ident_next++;
				tbl_active[idx] = 1;
				tbl_urgent[idx] = urg;
				tbl_running[idx] = 0;
				tbl_deadline[idx] = now + per;
				tbl_periodic[idx] = (cmd == tt_pkg::CMD_ADD_PER);
				tbl_threaded[idx] = (cmd == tt_pkg::CMD_ADD_PER) ? worker : 1'b1;
				tbl_policy[idx] = (cmd == tt_pkg::CMD_ADD_ONE || pol == 2'd3) ?
					tt_pkg::POL_OVERLAP : pol;
				tbl_interval[idx] = (cmd == tt_pkg::CMD_ADD_PER) ? per : 32'd0;
				pending_results.push_back(mk(tt_pkg::KIND_ADDED, tbl_ident[idx], 1'b0, 1'b0,
					32'd0, 1'b0, 1'b1));
			end
		end else if (cmd == tt_pkg::CMD_REMOVE || cmd == tt_pkg::CMD_DONE) begin
			for (int i = 0; i < tbl_used; i++)
				if (tbl_ident[i] == tid) begin
					idx = i;
					break;
				end
			if (idx >= 0) begin
				if (cmd == tt_pkg::CMD_REMOVE)
					tbl_active[idx] = 0;
				else if (tbl_running[idx] != 0)
					tbl_running[idx]--;
			end
			pending_results.push_back(mk(tt_pkg::KIND_ACK, 32'd0, 1'b0, 1'b0, 32'd0,
				idx >= 0, 1'b1));
		end else begin
			pending_results.push_back(mk(tt_pkg::KIND_ACK, 32'd0, 1'b0, 1'b0, 32'd0,
				1'b0, 1'b1));
		end
	endtask

	// Send one command transfer after a random gap, then predict it.
	// The block never takes a new command in the cycle after a transfer, so
	// the edge awaited before the gap costs no throughput.
	task automatic send_command(logic [2:0] cmd, logic [31:0] now, logic [31:0] per,
			logic worker, logic urg, logic [1:0] pol, logic [31:0] tid);
		@(posedge clk);
		repeat ($urandom_range(0, 3)) @(posedge clk);
		s_axis_tdata <= {6'd0, tid, urg, worker, per, now};
		s_axis_tuser <= {pol, cmd};
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		s_axis_tvalid <= 1'b0;
		predict_command(cmd, now, per, worker, urg, pol, tid);
	endtask

	// Hold until every expected result has arrived, then let the block settle.
	task automatic drain_results();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_sleep_cap(logic [15:0] value);
		drain_results();
		cfg_data <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		sleep_cap = value;
	endtask

	task automatic tick_at(logic [31:0] now);
		send_command(tt_pkg::CMD_TICK, now, $urandom, 1'($urandom), 1'($urandom),
			2'($urandom), $urandom);
	endtask

	// A recent id, or sometimes an arbitrary one.
	function automatic logic [31:0] pick_id();
		if ($urandom_range(0, 5) == 0)
			return $urandom;
		return ident_next - $urandom_range(1, 20);
	endfunction

	// Extremes of fields, every command, policies and overruns, wrap-around.
	task automatic test_directed();
		send_command(tt_pkg::CMD_ADD_ONE, 32'hFFFF_FFF0, 32'h20, 1'b0, 1'b1, 2'd3, 32'd0);
		send_command(tt_pkg::CMD_ADD_PER, 32'hFFFF_FFF0, 32'h5, 1'b1, 1'b0,
			tt_pkg::POL_OVERLAP, 32'd0);
		send_command(tt_pkg::CMD_ADD_PER, 32'hFFFF_FFF0, 32'h5, 1'b1, 1'b1,
			tt_pkg::POL_SKIP, 32'd0);
		send_command(tt_pkg::CMD_ADD_PER, 32'hFFFF_FFF0, 32'h5, 1'b1, 1'b0,
			tt_pkg::POL_WAIT, 32'd0);
		send_command(tt_pkg::CMD_ADD_PER, 32'hFFFF_FFF0, 32'h7, 1'b0, 1'b1, 2'd3,
			32'hFFFF_FFFF);
		tick_at(32'hFFFF_FFF0);
		tick_at(32'hFFFF_FFF5);
		tick_at(32'h0000_0010);
		tick_at(32'h0000_0020);
		send_command(tt_pkg::CMD_DONE, 32'd0, 32'd0, 1'b0, 1'b0, 2'd0, 32'd2);
		send_command(tt_pkg::CMD_DONE, 32'd0, 32'd0, 1'b0, 1'b0, 2'd0, 32'd4);
		send_command(tt_pkg::CMD_DONE, 32'd0, 32'd0, 1'b0, 1'b0, 2'd0, 32'd4);
		send_command(tt_pkg::CMD_DONE, 32'd0, 32'd0, 1'b0, 1'b0, 2'd0, 32'd4);
		send_command(tt_pkg::CMD_DONE, 32'd0, 32'd0, 1'b0, 1'b0, 2'd0, 32'd5);
		send_command(tt_pkg::CMD_REMOVE, 32'd0, 32'd0, 1'b0, 1'b0, 2'd0, 32'd1);
		send_command(tt_pkg::CMD_REMOVE, 32'd0, 32'd0, 1'b0, 1'b0, 2'd0, 32'hFFFF_FFFF);
		send_command(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 2'd3, 32'hFFFF_FFFF);
		send_command(3'd6, 32'd0, 32'd0, 1'b0, 1'b0, 2'd0, 32'd0);
		send_command(3'd7, 32'd0, 32'd0, 1'b0, 1'b0, 2'd0, 32'd0);
		tick_at(32'h8000_0000);
		for (int i = 0; i < 13; i++)
			send_command(tt_pkg::CMD_ADD_ONE, 32'd0, 32'hFFFF_FFFF, 1'b0, i[0], 2'd0, 32'd0);
		send_command(tt_pkg::CMD_ADD_PER, 32'd0, 32'd1, 1'b1, 1'b1, tt_pkg::POL_SKIP, 32'd0);
		drain_results();
	endtask

	// Mostly well-formed timer traffic at a moving clock.
	task automatic test_random_traffic(int count);
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				clock_ms += $urandom_range(0, 40);
				if ($urandom_range(0, 15) == 0)
					clock_ms = $urandom;
				tick_at(clock_ms);
				clock_ms = clock_ms;
			end else if (r < 50) begin
				send_command(tt_pkg::CMD_ADD_ONE, clock_ms, $urandom_range(0, 60),
					1'($urandom), 1'($urandom), 2'($urandom), $urandom);
			end else if (r < 68) begin
				send_command(tt_pkg::CMD_ADD_PER, clock_ms,
					($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 30),
					1'($urandom), 1'($urandom), 2'($urandom), $urandom);
			end else if (r < 78) begin
				send_command(tt_pkg::CMD_REMOVE, $urandom, $urandom, 1'($urandom),
					1'($urandom), 2'($urandom), pick_id());
			end else if (r < 96) begin
				send_command(tt_pkg::CMD_DONE, $urandom, $urandom, 1'($urandom),
					1'($urandom), 2'($urandom), pick_id());
			end else begin
				send_command(3'($urandom_range(5, 7)), $urandom, $urandom, 1'($urandom),
					1'($urandom), 2'($urandom), $urandom);
			end
			if (n == count / 2)
				drain_results();
		end
	endtask

	// Receiver: after each accepted result, draw how long tready stays low.
	always @(posedge clk) begin
		int draw;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			out_wait <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			draw = $urandom_range(0, 3);
			out_wait <= draw;
			m_axis_tready <= (draw == 0);
		end else if (m_axis_tvalid && !m_axis_tready) begin
			if (out_wait <= 1)
				m_axis_tready <= 1'b1;
			out_wait <= out_wait - 1;
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = mk(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[33],
				m_axis_tdata[65:34], m_axis_tdata[66], m_axis_tlast);
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d id %h", got.kind, got.task_id);
			end else begin
				want = pending_results.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected kind %0d id %h u %b t %b wake %h f %b l %b, got kind %0d id %h u %b t %b wake %h f %b l %b",
							want.kind, want.task_id, want.urgent_out, want.threaded_out,
							want.wake_ms, want.found, want.last, got.kind, got.task_id,
							got.urgent_out, got.threaded_out, got.wake_ms, got.found,
							got.last);
				end
			end
		end
	end

	// Watchdog: count cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		sleep_cap = tt_pkg::MAX_SLEEP_RESET;
		for (int i = 0; i < tt_pkg::SLOTS; i++) begin
			tbl_active[i] = 0; tbl_periodic[i] = 0; tbl_threaded[i] = 0; tbl_urgent[i] = 0;
			tbl_policy[i] = 0; tbl_running[i] = 0; tbl_deadline[i] = 0;
			tbl_interval[i] = 0; tbl_ident[i] = 0;
		end
		tbl_used = 0;
		ident_next = 32'd1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		write_sleep_cap(16'd1);
		test_random_traffic(50);
		write_sleep_cap(16'hFFFF);
		test_random_traffic(50);
		write_sleep_cap(16'($urandom_range(2, 200)));
		test_random_traffic(50);
		drain_results();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== timer_table_with_overrun_policy.f =====
rtl/tt_pkg.sv
rtl/tt_datapath.sv
rtl/tt_ctrl.sv
rtl/timer_table_with_overrun_policy.sv
rtl/tt_checker.sv
bench/tb_timer_table_with_overrun_policy.sv
